[sv/ordered_list_insert_remove_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the ordered list block
// Each macro expands to one labeled concurrent assertion on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_INSERT_REMOVE_DEFINES_SVH
`define ORDERED_LIST_INSERT_REMOVE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define OLI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define OLI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/oli_pkg.sv]
// ----------------------------------------------------------------------------
// oli_pkg
// Types and codes shared by the ordered list block, its cells and channels.
// ----------------------------------------------------------------------------
package oli_pkg;

  localparam int WORD_W  = 32;
  localparam int OP_W    = 3;
  localparam int POS_W   = 4;
  localparam int STAT_W  = 2;
  localparam int ECNT_W  = 5;

  typedef logic signed [WORD_W-1:0] word_t;

  localparam word_t VALUE_EMPTY = -1;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH       = 3'd0,
    OP_POP        = 3'd1,
    OP_REMOVE_AT  = 3'd2,
    OP_INSERT_AT  = 3'd3,
    OP_INSERT_MID = 3'd4,
    OP_REMOVE_MID = 3'd5
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // What every cell does at the next edge
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_OPEN,
    CELL_CLOSE
  } cell_mode_t;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [POS_W-1:0] position;
    word_t            data_word;
  } in_item_t;

  typedef struct packed {
    word_t             read_value;
    logic [STAT_W-1:0] status;
    logic [ECNT_W-1:0] entry_count;
  } out_item_t;

endpackage

[sv/oli_channels.sv]
// ----------------------------------------------------------------------------
// oli channels
// Valid/ready channel interfaces for the operation and result transactions.
// ----------------------------------------------------------------------------
interface oli_in_if;
  logic             valid;
  logic             ready;
  oli_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface oli_out_if;
  logic               valid;
  logic               ready;
  oli_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[sv/ordered_list_insert_remove.sv]
// ----------------------------------------------------------------------------
// ordered_list_insert_remove
// Bounded ordered list of signed 32-bit words held in a row of shift cells.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake            payload
//  --------  ----  -------------------  ---------------------------------------
//  in_ch     in    valid/ready          operation, position, data_word
//  out_ch    out   valid/ready          read_value, status, entry_count
//
//  One transaction per cycle while results drain: an insert or removal
//  shifts the whole list up or down at the edge that accepts it, every
//  cell moving at once, and the result is registered at that same edge.
//  A new transaction is taken while the output register is empty or being
//  drained in the same cycle; a stalled result holds the input side off.
//  Reset (rst_n low, synchronous) clears the count and the output valid;
//  entries are not cleared and need no clearing pass, as only entries below
//  the count are ever read.
// ----------------------------------------------------------------------------
`include "ordered_list_insert_remove_defines.svh"

module ordered_list_insert_remove #(
  parameter int CAPACITY = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  oli_in_if.sink     in_ch,
  oli_out_if.source  out_ch
);
  import oli_pkg::*;

  // count runs 0..CAPACITY, cell index 0..CAPACITY-1
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int WIDE_W = (CNT_W > ECNT_W) ? CNT_W : ECNT_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  out_item_t        out_item_r;

  // --------------------------------------------------------------------------
  // Handshake: the output register parts the two sides
  // --------------------------------------------------------------------------
  logic accept;
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // --------------------------------------------------------------------------
  // Decode the operation against the current count
  // --------------------------------------------------------------------------
  logic             full;
  logic             empty;
  logic             pos_ok;
  cell_mode_t       mode;
  cell_mode_t       cell_mode;
  logic [IDX_W-1:0] at_idx;
  logic [IDX_W-1:0] rd_idx;
  word_t            tail_word;
  word_t            value;
  status_t          status;

  assign full   = (count_r == CAP_CNT);
  assign empty  = (count_r == '0);
  assign pos_ok = CMP_W'(in_ch.payload.position) < CMP_W'(count_r);
  // last entry, read by a pop; don't care when the list is empty
  assign rd_idx = IDX_W'(count_r - CNT_W'(1));

  always_comb begin
    mode      = CELL_HOLD;
    at_idx    = '0;
    value     = '0;
    status    = ST_OK;
    count_nxt = count_r;
    unique case (in_ch.payload.operation)
      OP_PUSH: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          mode      = CELL_OPEN;
          at_idx    = IDX_W'(count_r);
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_POP: begin
        if (empty) begin
          status = ST_EMPTY;
          value  = VALUE_EMPTY;
        end else begin
          value     = tail_word;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_REMOVE_AT: begin
        if (!pos_ok) begin
          status = ST_RANGE;
        end else begin
          mode      = CELL_CLOSE;
          at_idx    = IDX_W'(in_ch.payload.position);
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_INSERT_AT: begin
        // index is checked before fullness; an insert never appends
        if (!pos_ok) begin
          status = ST_RANGE;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          mode      = CELL_OPEN;
          at_idx    = IDX_W'(in_ch.payload.position);
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_INSERT_MID: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          mode      = CELL_OPEN;
          at_idx    = IDX_W'(count_r >> 1);
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_REMOVE_MID: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          mode      = CELL_CLOSE;
          at_idx    = IDX_W'(count_r >> 1);
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: begin
        // unused opcodes: no change, ok status
        mode = CELL_HOLD;
      end
    endcase
  end

  // cells only move on an accepted transaction
  assign cell_mode = accept ? mode : CELL_HOLD;

  // --------------------------------------------------------------------------
  // Row of cells; each hands its entry to both neighbors
  // --------------------------------------------------------------------------
  word_t cell_data [CAPACITY];
  word_t cell_tap  [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    word_t left_w;
    word_t right_w;

    if (i == 0) begin : g_first
      assign left_w = in_ch.payload.data_word;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_w = cell_data[i];
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end

    oli_cell #(
      .IDX_W (IDX_W),
      .INDEX (i)
    ) u_cell (
      .clk        (clk),
      .mode       (cell_mode),
      .at_idx     (at_idx),
      .rd_idx     (rd_idx),
      .word       (in_ch.payload.data_word),
      .left_data  (left_w),
      .right_data (right_w),
      .data       (cell_data[i]),
      .tap        (cell_tap[i])
    );
  end

  // only the chosen cell drives a nonzero tap
  always_comb begin
    tail_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tail_word = tail_word | cell_tap[i];
    end
  end

  // --------------------------------------------------------------------------
  // Count and output register
  // --------------------------------------------------------------------------
  logic [WIDE_W-1:0] count_wide;
  out_item_t         out_nxt;

  assign count_wide            = WIDE_W'(count_nxt);
  assign out_nxt.read_value    = value;
  assign out_nxt.status        = status;
  assign out_nxt.entry_count   = count_wide[ECNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r <= out_nxt;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_item_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  logic [WIDE_W-1:0] count_r_wide;
  assign count_r_wide = WIDE_W'(count_r);

  `OLI_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CAP_CNT, "list count above capacity")
  `OLI_ASSERT_NEXT(a_push_grows, accept && in_ch.payload.operation == OP_PUSH && !full, count_r == $past(count_r) + CNT_W'(1), "push did not grow the list")
  `OLI_ASSERT_NEXT(a_result_count, accept, out_valid_r && out_item_r.entry_count == count_r_wide[ECNT_W-1:0], "result count differs from list count")
  `OLI_ASSERT_NOW(a_full_drop_status, accept && full && in_ch.payload.operation == OP_PUSH, out_nxt.status == ST_FULL && count_nxt == count_r, "push on full list not dropped")

endmodule

[sv/oli_cell.sv]
// ----------------------------------------------------------------------------
// oli_cell
// One list entry: holds, takes its left neighbor (open), its right neighbor
// (close) or the new word, and drives its entry onto the read tap when chosen.
// ----------------------------------------------------------------------------
module oli_cell #(
  parameter int IDX_W = 4,
  parameter int INDEX = 0
) (
  input  logic               clk,
  input  oli_pkg::cell_mode_t mode,
  input  logic [IDX_W-1:0]   at_idx,
  input  logic [IDX_W-1:0]   rd_idx,
  input  oli_pkg::word_t     word,
  input  oli_pkg::word_t     left_data,
  input  oli_pkg::word_t     right_data,
  output oli_pkg::word_t     data,
  output oli_pkg::word_t     tap
);
  import oli_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  word_t data_r;
  word_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (mode)
      CELL_OPEN: begin
        if (at_idx == MY_IDX) begin
          data_nxt = word;
        end else if (MY_IDX > at_idx) begin
          data_nxt = left_data;
        end
      end
      CELL_CLOSE: begin
        if (MY_IDX >= at_idx) begin
          data_nxt = right_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;
  assign tap  = (rd_idx == MY_IDX) ? data_r : '0;

endmodule
